// File: sv/s2x_pkg.sv
// Shared types, widths and codes for the Scale2x pixel upscaler.
`timescale 1ns / 1ps

package s2x_pkg;

   localparam int PIXEL_W           = 32;
   localparam int SRC_COL_W         = 10;
   localparam int SRC_ROW_W         = 12;
   localparam int FRAME_WIDTH_W     = 11;
   localparam int FRAME_HEIGHT_W    = 13;
   localparam int PIXEL_BYTES_W     = 3;
   localparam int CSR_INDEX_W       = 2;
   localparam int CSR_DATA_W        = 13;
   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int MAX_HEIGHT        = 4096;

   // Register reset values.
   localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 11'd1024;
   localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 13'd768;
   localparam logic [PIXEL_BYTES_W-1:0]  PIXEL_BYTES_RESET  = 3'd4;

   // Register indexes on the configuration channel.
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PIXEL_BYTES  = 2'd2;

   // Input item kinds.
   localparam logic FUNC_PIXEL = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   typedef enum logic {
      PHASE_RECEIVE,
      PHASE_DRAIN
   } phase_type;

   // Masked 3x3 cross around the centre pixel.
   typedef struct packed {
      logic [PIXEL_W-1:0] above;
      logic [PIXEL_W-1:0] left;
      logic [PIXEL_W-1:0] centre;
      logic [PIXEL_W-1:0] right;
      logic [PIXEL_W-1:0] below;
   } window_type;

   // The 2x2 block produced from one source pixel.
   typedef struct packed {
      logic [PIXEL_W-1:0] top_left;
      logic [PIXEL_W-1:0] top_right;
      logic [PIXEL_W-1:0] bottom_left;
      logic [PIXEL_W-1:0] bottom_right;
   } block_type;

endpackage

// File: sv/s2x_channels.sv
// Valid/ready channel interfaces for the upscaler's input, result and register ports.
`timescale 1ns / 1ps

interface s2x_req_if;
   import s2x_pkg::*;
   logic               valid;
   logic               ready;
   logic               func;
   logic [PIXEL_W-1:0] pixel;
   modport source (output valid, output func, output pixel, input ready);
   modport sink   (input valid, input func, input pixel, output ready);
endinterface

interface s2x_rsp_if;
   import s2x_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [PIXEL_W-1:0]   top_left;
   logic [PIXEL_W-1:0]   top_right;
   logic [PIXEL_W-1:0]   bottom_left;
   logic [PIXEL_W-1:0]   bottom_right;
   logic [SRC_COL_W-1:0] src_col;
   logic [SRC_ROW_W-1:0] src_row;
   logic                 frame_last;
   modport source (output valid, output top_left, output top_right, output bottom_left,
                   output bottom_right, output src_col, output src_row, output frame_last,
                   input ready);
   modport sink   (input valid, input top_left, input top_right, input bottom_left,
                   input bottom_right, input src_col, input src_row, input frame_last,
                   output ready);
endinterface

interface s2x_csr_if;
   import s2x_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/s2x_ram.sv
// Generic single-write, dual-read RAM with registered, read-first outputs.
`timescale 1ns / 1ps

module s2x_ram #(
   parameter  int WIDTH = 32,
   parameter  int DEPTH = 1024,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             write_en,
   input  logic [AW-1:0]    write_addr,
   input  logic [WIDTH-1:0] write_data,
   input  logic             read_en,
   input  logic [AW-1:0]    read_addr0,
   input  logic [AW-1:0]    read_addr1,
   output logic [WIDTH-1:0] read_data0,
   output logic [WIDTH-1:0] read_data1
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data0_ff;
   logic [WIDTH-1:0] read_data1_ff;

   always_ff @(posedge clock) begin
      if (read_en) begin
         read_data0_ff <= mem_ff[read_addr0];
         read_data1_ff <= mem_ff[read_addr1];
      end
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
   end

   assign read_data0 = read_data0_ff;
   assign read_data1 = read_data1_ff;

endmodule

// File: sv/s2x_kernel.sv
// Scale2x selection rules: turns a masked pixel cross into one 2x2 block.
`timescale 1ns / 1ps

module s2x_kernel (
   input  s2x_pkg::window_type win,
   output s2x_pkg::block_type  blk
);
   import s2x_pkg::*;

   logic d_eq_b;
   logic b_eq_f;
   logic d_eq_h;
   logic h_eq_f;

   always_comb begin
      d_eq_b = (win.left  == win.above);
      b_eq_f = (win.above == win.right);
      d_eq_h = (win.left  == win.below);
      h_eq_f = (win.below == win.right);

      blk.top_left     = (d_eq_b && !b_eq_f && !d_eq_h) ? win.left  : win.centre;
      blk.top_right    = (b_eq_f && !d_eq_b && !h_eq_f) ? win.right : win.centre;
      blk.bottom_left  = (d_eq_h && !d_eq_b && !h_eq_f) ? win.left  : win.centre;
      blk.bottom_right = (h_eq_f && !d_eq_h && !b_eq_f) ? win.right : win.centre;
   end

endmodule

// File: sv/scale2x_pixel_upscaler_core.sv
// Top level of the streaming Scale2x pixel upscaler.
// Usage: source pixels enter on req_chan in raster order (func = pixel), one transaction
// each. Two line stores hold the newest completed row and the row before it; the 2x2
// block for row r, column c leaves on rsp_chan once pixel (r+1, c) has been taken, so
// row 0 gives no results. After the last row the sender issues drain transactions
// (func = drain), one per column, and the final block of the frame has frame_last set.
// Drain transactions during reception and pixels during draining are taken and dropped.
// Registers (frame_width, frame_height, pixel_bytes) are written on csr_chan, which is
// always ready; write them only while no result is outstanding.
// A result is registered on rsp_chan after its input transaction is taken (line-store
// read into the stage 1 registers, then the selection logic into the output register).
// Throughput: one transaction per clock while rsp_chan is not stalled; the two line-store
// read ports and the single write port serve every item.
// When the receiver stalls, the output register and the stage behind it fill, then
// req_chan.ready drops until rsp_chan is taken.
// Reset clears the counters, phase and row select and restores the register defaults;
// the line stores are not cleared, since every entry is written before it is read.
`timescale 1ns / 1ps

module scale2x_pixel_upscaler_core #(
   parameter int MAX_WIDTH = s2x_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   s2x_req_if.sink   req_chan,
   s2x_rsp_if.source rsp_chan,
   s2x_csr_if.sink   csr_chan
);
   import s2x_pkg::*;

   // Column addresses, the effective width (which may equal MAX_WIDTH) and a compare width
   // wide enough for both the width register and MAX_WIDTH.
   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int CW = (WW > FRAME_WIDTH_W) ? WW : FRAME_WIDTH_W;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [FRAME_WIDTH_W-1:0]  frame_width_ff;
   logic [FRAME_HEIGHT_W-1:0] frame_height_ff;
   logic [PIXEL_BYTES_W-1:0]  pixel_bytes_ff;
   logic                      csr_fire;

   assign csr_chan.ready = 1'b1;
   assign csr_fire       = csr_chan.valid & csr_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         pixel_bytes_ff  <= PIXEL_BYTES_RESET;
      end else if (csr_fire) begin
         unique case (csr_chan.index)
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_chan.data[FRAME_WIDTH_W-1:0];
            REG_FRAME_HEIGHT: frame_height_ff <= csr_chan.data[FRAME_HEIGHT_W-1:0];
            REG_PIXEL_BYTES:  pixel_bytes_ff  <= csr_chan.data[PIXEL_BYTES_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective settings: out-of-range values are pulled into the legal range.
   logic [CW-1:0]             width_ext;
   logic [WW-1:0]             eff_width;
   logic [FRAME_HEIGHT_W-1:0] eff_height;
   logic [PIXEL_W-1:0]        pixel_mask;

   assign width_ext = CW'(frame_width_ff);

   always_comb begin
      if (width_ext == '0) begin
         eff_width = WW'(1);
      end else if (width_ext > CW'(MAX_WIDTH)) begin
         eff_width = WW'(MAX_WIDTH);
      end else begin
         eff_width = WW'(width_ext);
      end

      if (frame_height_ff == '0) begin
         eff_height = FRAME_HEIGHT_W'(1);
      end else if (frame_height_ff > FRAME_HEIGHT_W'(MAX_HEIGHT)) begin
         eff_height = FRAME_HEIGHT_W'(MAX_HEIGHT);
      end else begin
         eff_height = frame_height_ff;
      end

      unique case (pixel_bytes_ff)
         3'd0, 3'd1: pixel_mask = 32'h0000_00FF;
         3'd2:       pixel_mask = 32'h0000_FFFF;
         3'd3:       pixel_mask = 32'h00FF_FFFF;
         default:    pixel_mask = 32'hFFFF_FFFF;
      endcase
   end

   // ------------------------------------------------------------------
   // Position counters and phase
   // ------------------------------------------------------------------
   phase_type            phase_ff, phase_in;
   logic [AW-1:0]        col_ff, col_in;
   logic [AW-1:0]        drain_col_ff, drain_col_in;
   logic [SRC_ROW_W-1:0] row_ff, row_in;
   logic                 newest_sel_ff, newest_sel_in;

   logic                      req_fire;
   logic [AW-1:0]             cur_col;
   logic [WW-1:0]             col_next;
   logic                      at_row_end;
   logic [AW-1:0]             right_addr;
   logic [FRAME_HEIGHT_W-1:0] row_next;
   logic                      last_row;
   logic [PIXEL_W-1:0]        pixel_masked;

   // Per-phase decode of the transaction on req_chan.
   logic                 item_taken;
   logic                 item_gives_block;
   logic                 above_is_centre;
   logic [SRC_ROW_W-1:0] block_row;
   logic                 block_last;
   logic                 store_write;

   assign cur_col      = (phase_ff == PHASE_DRAIN) ? drain_col_ff : col_ff;
   assign col_next     = WW'(cur_col) + WW'(1);
   assign at_row_end   = (col_next >= eff_width);
   assign right_addr   = at_row_end ? AW'(eff_width - WW'(1)) : AW'(col_next);
   assign row_next     = FRAME_HEIGHT_W'(row_ff) + FRAME_HEIGHT_W'(1);
   assign last_row     = (row_next >= eff_height);
   assign pixel_masked = req_chan.pixel & pixel_mask;

   // Next phase: reception ends with the last pixel of the last row, draining with the
   // last column of that row.
   always_comb begin
      phase_in = phase_ff;
      if (req_fire && item_taken && at_row_end) begin
         unique case (phase_ff)
            PHASE_RECEIVE: if (last_row) phase_in = PHASE_DRAIN;
            PHASE_DRAIN:   phase_in = PHASE_RECEIVE;
            default:       phase_in = phase_ff;
         endcase
      end
   end

   // Phase outputs. While receiving, the block belongs to the row above the arriving pixel
   // and its upper neighbour comes from the older store (or is the centre for row 1).
   // While draining, the lower neighbour is the centre and frame_last marks the last column.
   always_comb begin
      unique case (phase_ff)
         PHASE_DRAIN: begin
            item_taken       = (req_chan.func == FUNC_DRAIN);
            item_gives_block = item_taken;
            above_is_centre  = (row_ff == '0);
            block_row        = row_ff;
            block_last       = at_row_end;
            store_write      = 1'b0;
         end
         default: begin
            item_taken       = (req_chan.func == FUNC_PIXEL);
            item_gives_block = item_taken && (row_ff != '0);
            above_is_centre  = (row_ff == SRC_ROW_W'(1));
            block_row        = row_ff - SRC_ROW_W'(1);
            block_last       = 1'b0;
            store_write      = req_fire && item_taken;
         end
      endcase
   end

   // Counter updates.
   always_comb begin
      col_in        = col_ff;
      drain_col_in  = drain_col_ff;
      row_in        = row_ff;
      newest_sel_in = newest_sel_ff;
      if (req_fire && item_taken) begin
         if (phase_ff == PHASE_RECEIVE) begin
            if (at_row_end) begin
               col_in        = '0;
               newest_sel_in = ~newest_sel_ff;
               if (last_row) begin
                  drain_col_in = '0;
               end else begin
                  row_in = SRC_ROW_W'(row_next);
               end
            end else begin
               col_in = AW'(col_next);
            end
         end else begin
            if (at_row_end) begin
               drain_col_in = '0;
               col_in       = '0;
               row_in       = '0;
            end else begin
               drain_col_in = AW'(col_next);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_RECEIVE;
         col_ff        <= '0;
         drain_col_ff  <= '0;
         row_ff        <= '0;
         newest_sel_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         col_ff        <= col_in;
         drain_col_ff  <= drain_col_in;
         row_ff        <= row_in;
         newest_sel_ff <= newest_sel_in;
      end
   end

   // ------------------------------------------------------------------
   // Line stores. Both are read at the current column and at its right neighbour; the
   // arriving pixel is written into the older store, which becomes the newest at row end.
   // The older store's read-first port still returns the row two above.
   // ------------------------------------------------------------------
   logic [PIXEL_W-1:0] store_a_centre, store_a_right;
   logic [PIXEL_W-1:0] store_b_centre, store_b_right;

   s2x_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_store_a (
      .clock      (clock),
      .write_en   (store_write & newest_sel_ff),
      .write_addr (cur_col),
      .write_data (pixel_masked),
      .read_en    (req_fire),
      .read_addr0 (cur_col),
      .read_addr1 (right_addr),
      .read_data0 (store_a_centre),
      .read_data1 (store_a_right)
   );

   s2x_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_store_b (
      .clock      (clock),
      .write_en   (store_write & ~newest_sel_ff),
      .write_addr (cur_col),
      .write_data (pixel_masked),
      .read_en    (req_fire),
      .read_addr0 (cur_col),
      .read_addr1 (right_addr),
      .read_data0 (store_b_centre),
      .read_data1 (store_b_right)
   );

   // ------------------------------------------------------------------
   // Stage 1: the line-store data is in the RAM output registers; the block is selected
   // here and captured in the output register.
   // ------------------------------------------------------------------
   logic                 s1_valid_ff, s1_valid_in;
   logic [AW-1:0]        s1_col_ff;
   logic [SRC_ROW_W-1:0] s1_row_ff;
   logic                 s1_last_ff;
   logic                 s1_above_is_centre_ff;
   logic                 s1_drain_ff;
   logic                 s1_newest_sel_ff;
   logic [PIXEL_W-1:0]   s1_pixel_ff;
   logic [PIXEL_W-1:0]   left_raw_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_advance;
   logic [PIXEL_W-1:0] newest_centre, newest_right, older_centre;
   window_type         win;
   block_type          blk;

   block_type            out_blk_ff;
   logic [SRC_COL_W-1:0] out_col_ff;
   logic [SRC_ROW_W-1:0] out_row_ff;
   logic                 out_last_ff;

   assign out_advance    = ~rsp_valid_ff | rsp_chan.ready;
   assign req_chan.ready = ~s1_valid_ff | out_advance;
   assign req_fire       = req_chan.valid & req_chan.ready;

   assign s1_valid_in  = (req_fire & item_gives_block) | (s1_valid_ff & ~out_advance);
   assign rsp_valid_in = (s1_valid_ff & out_advance) | (rsp_valid_ff & ~rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && item_gives_block) begin
         s1_col_ff             <= cur_col;
         s1_row_ff             <= block_row;
         s1_last_ff            <= block_last;
         s1_above_is_centre_ff <= above_is_centre;
         s1_drain_ff           <= (phase_ff == PHASE_DRAIN);
         s1_newest_sel_ff      <= newest_sel_ff;
         s1_pixel_ff           <= pixel_masked;
      end
      // The centre of one block is the left neighbour of the next in the same row.
      if (s1_valid_ff && out_advance) begin
         left_raw_ff <= newest_centre;
      end
   end

   assign newest_centre = s1_newest_sel_ff ? store_b_centre : store_a_centre;
   assign newest_right  = s1_newest_sel_ff ? store_b_right  : store_a_right;
   assign older_centre  = s1_newest_sel_ff ? store_a_centre : store_b_centre;

   // Stored pixels are masked again, since pixel_bytes may have changed since the write.
   always_comb begin
      win.centre = newest_centre & pixel_mask;
      win.right  = newest_right & pixel_mask;
      win.left   = (s1_col_ff == '0) ? win.centre : (left_raw_ff & pixel_mask);
      win.above  = s1_above_is_centre_ff ? win.centre : (older_centre & pixel_mask);
      win.below  = s1_drain_ff ? win.centre : s1_pixel_ff;
   end

   s2x_kernel u_kernel (
      .win (win),
      .blk (blk)
   );

   always_ff @(posedge clock) begin
      if (s1_valid_ff && out_advance) begin
         out_blk_ff  <= blk;
         out_col_ff  <= SRC_COL_W'(s1_col_ff);
         out_row_ff  <= s1_row_ff;
         out_last_ff <= s1_last_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.top_left     = out_blk_ff.top_left;
   assign rsp_chan.top_right    = out_blk_ff.top_right;
   assign rsp_chan.bottom_left  = out_blk_ff.bottom_left;
   assign rsp_chan.bottom_right = out_blk_ff.bottom_right;
   assign rsp_chan.src_col      = out_col_ff;
   assign rsp_chan.src_row      = out_row_ff;
   assign rsp_chan.frame_last   = out_last_ff;

`ifndef NO_ASSERTIONS
   // Draining starts at a row boundary, so the reception column stays at zero meanwhile.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PHASE_DRAIN) |-> (col_ff == '0))
      else $error("reception column moved while draining");

   // The drain column is only used while draining and is back at zero otherwise.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PHASE_RECEIVE) |-> (drain_col_ff == '0))
      else $error("drain column not cleared outside draining");

   // The line stores swap roles only after the last pixel of a row has been taken.
   assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && !$stable(newest_sel_ff)) |->
         $past(req_fire && item_taken && at_row_end && (phase_ff == PHASE_RECEIVE)))
      else $error("line store select changed away from a row end");

   // A block waiting in stage 1 must not be lost while the output register is full.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_advance) |=> s1_valid_ff)
      else $error("stage 1 block dropped under back-pressure");
`endif

endmodule
